// File: design/rmd160_pkg.sv
// rmd160_pkg: types, constants and step functions for the ripemd-160 engine
// no dependencies
package rmd160_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       absorb;
        logic [7:0] absorb_byte;
        logic       len_bytes;
        logic       latch_len;
        logic       comp_start;
        logic       comp_step;
        logic       fold;
        logic       emit_load;
        logic       restart;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       comp_last;
    } dp_stat_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [6:0] LAST_STEP = 7'd79;
    localparam logic [2:0] LAST_WORD = 3'd4;

    function automatic logic [31:0] k_left(input logic [2:0] g);
        unique case (g)
            3'd0:    k_left = 32'h00000000;
            3'd1:    k_left = 32'h5A827999;
            3'd2:    k_left = 32'h6ED9EBA1;
            3'd3:    k_left = 32'h8F1BBCDC;
            default: k_left = 32'hA953FD4E;
        endcase
    endfunction

    function automatic logic [31:0] k_right(input logic [2:0] g);
        unique case (g)
            3'd0:    k_right = 32'h50A28BE6;
            3'd1:    k_right = 32'h5C4DD124;
            3'd2:    k_right = 32'h6D703EF3;
            3'd3:    k_right = 32'h7A6D76E9;
            default: k_right = 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] bool_fn(input logic [2:0] g, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        unique case (g)
            3'd0:    bool_fn = x ^ y ^ z;
            3'd1:    bool_fn = (x & y) | (~x & z);
            3'd2:    bool_fn = (x | ~y) ^ z;
            3'd3:    bool_fn = (x & z) | (y & ~z);
            default: bool_fn = x ^ (y | ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        rotl = d[63:32];
    endfunction

    localparam logic [319:0] SEL_L = {
        4'd13,4'd15,4'd6,4'd11,4'd8,4'd3,4'd1,4'd14,4'd10,4'd2,4'd12,4'd7,4'd9,4'd5,4'd0,4'd4,
        4'd2,4'd6,4'd5,4'd14,4'd15,4'd7,4'd3,4'd13,4'd4,4'd12,4'd8,4'd0,4'd10,4'd11,4'd9,4'd1,
        4'd12,4'd5,4'd11,4'd13,4'd6,4'd0,4'd7,4'd2,4'd1,4'd8,4'd15,4'd9,4'd4,4'd14,4'd10,4'd3,
        4'd8,4'd11,4'd14,4'd2,4'd5,4'd9,4'd0,4'd12,4'd3,4'd15,4'd6,4'd10,4'd1,4'd13,4'd4,4'd7,
        4'd15,4'd14,4'd13,4'd12,4'd11,4'd10,4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0};
    localparam logic [319:0] SEL_R = {
        4'd11,4'd9,4'd3,4'd0,4'd14,4'd13,4'd2,4'd6,4'd7,4'd8,4'd5,4'd1,4'd4,4'd10,4'd15,4'd12,
        4'd14,4'd10,4'd7,4'd9,4'd13,4'd2,4'd12,4'd5,4'd0,4'd15,4'd11,4'd3,4'd1,4'd4,4'd6,4'd8,
        4'd13,4'd4,4'd0,4'd10,4'd2,4'd12,4'd8,4'd11,4'd9,4'd6,4'd14,4'd7,4'd3,4'd1,4'd5,4'd15,
        4'd2,4'd1,4'd9,4'd4,4'd12,4'd8,4'd15,4'd14,4'd10,4'd5,4'd13,4'd0,4'd7,4'd3,4'd11,4'd6,
        4'd12,4'd3,4'd10,4'd1,4'd8,4'd15,4'd6,4'd13,4'd4,4'd11,4'd2,4'd9,4'd0,4'd7,4'd14,4'd5};
    localparam logic [399:0] ROT_L = {
        5'd6,5'd5,5'd8,5'd11,5'd14,5'd13,5'd12,5'd5,5'd12,5'd13,5'd8,5'd6,5'd11,5'd5,5'd15,5'd9,
        5'd12,5'd5,5'd6,5'd8,5'd6,5'd5,5'd14,5'd9,5'd8,5'd9,5'd15,5'd14,5'd15,5'd14,5'd12,5'd11,
        5'd5,5'd7,5'd12,5'd5,5'd6,5'd13,5'd8,5'd14,5'd15,5'd13,5'd9,5'd14,5'd7,5'd6,5'd13,5'd11,
        5'd12,5'd13,5'd7,5'd11,5'd9,5'd15,5'd12,5'd7,5'd15,5'd7,5'd9,5'd11,5'd13,5'd8,5'd6,5'd7,
        5'd8,5'd9,5'd7,5'd6,5'd15,5'd14,5'd13,5'd11,5'd9,5'd7,5'd8,5'd5,5'd12,5'd15,5'd14,5'd11};
    localparam logic [399:0] ROT_R = {
        5'd11,5'd11,5'd13,5'd15,5'd5,5'd6,5'd13,5'd8,5'd6,5'd14,5'd5,5'd12,5'd9,5'd12,5'd5,5'd8,
        5'd8,5'd15,5'd5,5'd12,5'd9,5'd12,5'd9,5'd6,5'd14,5'd6,5'd14,5'd14,5'd11,5'd8,5'd5,5'd15,
        5'd5,5'd7,5'd13,5'd13,5'd14,5'd5,5'd13,5'd12,5'd14,5'd6,5'd6,5'd8,5'd11,5'd15,5'd7,5'd9,
        5'd11,5'd13,5'd15,5'd6,5'd7,5'd12,5'd7,5'd7,5'd11,5'd9,5'd8,5'd12,5'd7,5'd15,5'd13,5'd9,
        5'd6,5'd12,5'd14,5'd14,5'd11,5'd8,5'd7,5'd7,5'd5,5'd15,5'd15,5'd13,5'd11,5'd9,5'd9,5'd8};

endpackage

// File: design/ripemd160_hash_engine_core.sv
// ripemd160_hash_engine_core: streaming ripemd-160, one byte per beat
// depends on rmd160_pkg, rmd160_ctrl, rmd160_dp
// data beat: one that completes a 64-byte block is followed by 80 steps plus fold
// finish beat: padding and length bytes, one or two compressions (80 steps plus fold
// each), then five result beats at one per cycle while m_tready is high
// throughput is set by the single round unit per line
// synchronous active-low reset restores the initial chaining value and clears the count
module ripemd160_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    rmd160_pkg::dp_cmd_t  cmd;
    rmd160_pkg::dp_stat_t stat;
    logic        emit_busy, emit_done;
    logic [2:0]  idx_reg;
    logic [31:0] word;

    assign m_tvalid  = emit_busy;
    assign m_tdata   = word;
    assign m_tuser   = idx_reg;
    assign m_tlast   = (idx_reg == rmd160_pkg::LAST_WORD);
    assign emit_done = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit_load)
            idx_reg <= '0;
        else if (m_tvalid && m_tready && !m_tlast)
            idx_reg <= idx_reg + 3'd1;
    end

    rmd160_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .emit_busy (emit_busy),
        .emit_done (emit_done),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmd160_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .out_sel   (idx_reg),
        .out_word  (word),
        .stat      (stat)
    );

endmodule

// File: design/rmd160_ctrl.sv
// rmd160_ctrl: sequencer for absorb, padding, compression and digest output
// depends on rmd160_pkg
module rmd160_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_mode,
    input  logic [7:0]           in_byte,
    output logic                 in_ready,
    output logic                 emit_busy,
    input  logic                 emit_done,
    input  rmd160_pkg::dp_stat_t stat,
    output rmd160_pkg::dp_cmd_t  cmd
);

    rmd160_pkg::state_t state_reg, state_next;
    logic finishing_reg, finishing_next;
    logic len_done_reg, len_done_next;
    logic acc;

    assign acc = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rmd160_pkg::ST_IDLE;
            finishing_reg <= 1'b0;
            len_done_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            finishing_reg <= finishing_next;
            len_done_reg  <= len_done_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        finishing_next = finishing_reg;
        len_done_next  = len_done_reg;
        unique case (state_reg)
            rmd160_pkg::ST_IDLE: begin
                if (acc) begin
                    if (in_mode) begin
                        finishing_next = 1'b1;
                        state_next = (stat.pos == 6'd63) ? rmd160_pkg::ST_COMP
                                   : (stat.pos == 6'd55) ? rmd160_pkg::ST_LEN
                                   : rmd160_pkg::ST_PAD;
                    end else if (stat.pos == 6'd63) begin
                        state_next = rmd160_pkg::ST_COMP;
                    end
                end
            end
            rmd160_pkg::ST_PAD: begin
                if (stat.pos == 6'd63)
                    state_next = rmd160_pkg::ST_COMP;
                else if (stat.pos == 6'd55)
                    state_next = rmd160_pkg::ST_LEN;
            end
            rmd160_pkg::ST_LEN: begin
                if (stat.pos == 6'd63) begin
                    state_next    = rmd160_pkg::ST_COMP;
                    len_done_next = 1'b1;
                end
            end
            rmd160_pkg::ST_COMP: begin
                if (stat.comp_last)
                    state_next = rmd160_pkg::ST_FOLD;
            end
            rmd160_pkg::ST_FOLD: begin
                if (!finishing_reg)
                    state_next = rmd160_pkg::ST_IDLE;
                else if (len_done_reg)
                    state_next = rmd160_pkg::ST_EMIT;
                else
                    state_next = rmd160_pkg::ST_PAD;
            end
            rmd160_pkg::ST_EMIT: begin
                if (emit_done) begin
                    state_next     = rmd160_pkg::ST_IDLE;
                    finishing_next = 1'b0;
                    len_done_next  = 1'b0;
                end
            end
            default: state_next = rmd160_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        emit_busy = 1'b0;
        unique case (state_reg)
            rmd160_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (acc) begin
                    cmd.absorb      = 1'b1;
                    cmd.absorb_byte = in_mode ? 8'h80 : in_byte;
                    cmd.latch_len   = in_mode;
                    cmd.comp_start  = (stat.pos == 6'd63);
                end
            end
            rmd160_pkg::ST_PAD: begin
                cmd.absorb     = 1'b1;
                cmd.comp_start = (stat.pos == 6'd63);
            end
            rmd160_pkg::ST_LEN: begin
                cmd.absorb     = 1'b1;
                cmd.absorb_byte = 8'h00;
                cmd.len_bytes  = 1'b1;
                cmd.comp_start = (stat.pos == 6'd63);
            end
            rmd160_pkg::ST_COMP: cmd.comp_step = 1'b1;
            rmd160_pkg::ST_FOLD: begin
                cmd.fold      = 1'b1;
                cmd.emit_load = finishing_reg && len_done_reg;
            end
            rmd160_pkg::ST_EMIT: begin
                emit_busy   = 1'b1;
                cmd.restart = emit_done;
            end
            default: ;
        endcase
    end

endmodule

// File: design/rmd160_dp.sv
// rmd160_dp: block store, byte counter, length bytes, two round lines and chaining value
// depends on rmd160_pkg
module rmd160_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rmd160_pkg::dp_cmd_t  cmd,
    input  logic [2:0]           out_sel,
    output logic [31:0]          out_word,
    output rmd160_pkg::dp_stat_t stat
);

    logic [31:0] blk_reg [16];
    logic [60:0] cnt_reg;
    logic [63:0] bits_reg;
    logic [31:0] cv_reg [5];
    logic [31:0] al_reg, bl_reg, cl_reg, dl_reg, el_reg;
    logic [31:0] ar_reg, br_reg, cr_reg, dr_reg, er_reg;
    logic [6:0]  step_reg;
    logic [5:0]  pos;
    logic [7:0]  wbyte;
    logic [2:0]  g, gr;
    logic [3:0]  sl, sr;
    logic [4:0]  rl, rr;
    logic [31:0] tl, tr;

    assign pos = cnt_reg[5:0];
    assign stat.pos = pos;
    assign stat.comp_last = (step_reg == rmd160_pkg::LAST_STEP);
    assign out_word = cv_reg[out_sel];

    always_comb begin
        wbyte = cmd.absorb_byte;
        if (cmd.len_bytes)
            wbyte = bits_reg[8*pos[2:0] +: 8];
    end

    assign g  = step_reg[6:4];
    assign gr = 3'd4 - g;
    assign sl = rmd160_pkg::SEL_L[4*step_reg +: 4];
    assign sr = rmd160_pkg::SEL_R[4*step_reg +: 4];
    assign rl = rmd160_pkg::ROT_L[5*step_reg +: 5];
    assign rr = rmd160_pkg::ROT_R[5*step_reg +: 5];
    assign tl = rmd160_pkg::rotl(al_reg + rmd160_pkg::bool_fn(g, bl_reg, cl_reg, dl_reg)
                + blk_reg[sl] + rmd160_pkg::k_left(g), rl) + el_reg;
    assign tr = rmd160_pkg::rotl(ar_reg + rmd160_pkg::bool_fn(gr, br_reg, cr_reg, dr_reg)
                + blk_reg[sr] + rmd160_pkg::k_right(g), rr) + er_reg;

    always_ff @(posedge aclk) begin
        if (cmd.absorb)
            blk_reg[pos[5:2]][8*pos[1:0] +: 8] <= wbyte;
        if (cmd.latch_len)
            bits_reg <= {cnt_reg, 3'b000};
        if (cmd.comp_start) begin
            al_reg <= cv_reg[0]; bl_reg <= cv_reg[1]; cl_reg <= cv_reg[2];
            dl_reg <= cv_reg[3]; el_reg <= cv_reg[4];
            ar_reg <= cv_reg[0]; br_reg <= cv_reg[1]; cr_reg <= cv_reg[2];
            dr_reg <= cv_reg[3]; er_reg <= cv_reg[4];
        end else if (cmd.comp_step) begin
            al_reg <= el_reg; el_reg <= dl_reg; dl_reg <= rmd160_pkg::rotl(cl_reg, 5'd10);
            cl_reg <= bl_reg; bl_reg <= tl;
            ar_reg <= er_reg; er_reg <= dr_reg; dr_reg <= rmd160_pkg::rotl(cr_reg, 5'd10);
            cr_reg <= br_reg; br_reg <= tr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            cnt_reg  <= '0;
            step_reg <= '0;
            cv_reg[0] <= rmd160_pkg::IV0; cv_reg[1] <= rmd160_pkg::IV1;
            cv_reg[2] <= rmd160_pkg::IV2; cv_reg[3] <= rmd160_pkg::IV3;
            cv_reg[4] <= rmd160_pkg::IV4;
        end else begin
            if (cmd.absorb)
                cnt_reg <= cnt_reg + 61'd1;
            if (cmd.comp_start)
                step_reg <= '0;
            else if (cmd.comp_step)
                step_reg <= step_reg + 7'd1;
            if (cmd.fold) begin
                cv_reg[0] <= cv_reg[1] + cl_reg + dr_reg;
                cv_reg[1] <= cv_reg[2] + dl_reg + er_reg;
                cv_reg[2] <= cv_reg[3] + el_reg + ar_reg;
                cv_reg[3] <= cv_reg[4] + al_reg + br_reg;
                cv_reg[4] <= cv_reg[0] + bl_reg + cr_reg;
            end
        end
    end

endmodule

// File: sim/rmd160_checker.sv
// rmd160_checker: watches both channels of the ripemd-160 engine, predicts each digest
// from the accepted input beats and compares every result beat field by field
// depends on nothing but the engine's port widths
module rmd160_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV_W [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] KL [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                       32'h8F1BBCDC, 32'hA953FD4E};
    localparam logic [31:0] KR [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                       32'h7A6D76E9, 32'h00000000};
    localparam int WL [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    localparam int WR [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    localparam int SL [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    localparam int SR [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [60:0]  nbytes;
    digest_beat_t digest_q [$];
    int           mismatches = 0;

    function automatic logic [31:0] rol(logic [31:0] v, int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic logic [31:0] mix(int g, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        case (g)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    task automatic compress_block();
        logic [31:0] al, bl, cl, dl, el, ar, br, cr, dr, er, t;
        int g;
        al = chain[0]; bl = chain[1]; cl = chain[2]; dl = chain[3]; el = chain[4];
        ar = al; br = bl; cr = cl; dr = dl; er = el;
        for (int j = 0; j < 80; j++) begin
            g = j / 16;
            t = rol(al + mix(g, bl, cl, dl) + blk[WL[j]] + KL[g], SL[j]) + el;
            al = el; el = dl; dl = rol(cl, 10); cl = bl; bl = t;
            t = rol(ar + mix(4 - g, br, cr, dr) + blk[WR[j]] + KR[g], SR[j]) + er;
            ar = er; er = dr; dr = rol(cr, 10); cr = br; br = t;
        end
        t = chain[1] + cl + dr;
        chain[1] = chain[2] + dl + er;
        chain[2] = chain[3] + el + ar;
        chain[3] = chain[4] + al + br;
        chain[4] = chain[0] + bl + cr;
        chain[0] = t;
    endtask

    task automatic take_byte(logic [7:0] b);
        int pos;
        pos = nbytes[5:0];
        blk[pos / 4][(pos % 4) * 8 +: 8] = b;
        nbytes = nbytes + 1;
        if (pos == 63) compress_block();
    endtask

    task automatic clear_state();
        foreach (chain[i]) chain[i] = IV_W[i];
        foreach (blk[i]) blk[i] = '0;
        nbytes = '0;
    endtask

    task automatic finish_message();
        logic [63:0] bits;
        digest_beat_t d;
        bits = {nbytes, 3'b000};
        take_byte(8'h80);
        while (nbytes[5:0] != 6'd56) take_byte(8'h00);
        for (int i = 0; i < 8; i++) take_byte(bits[8 * i +: 8]);
        for (int i = 0; i < 5; i++) begin
            d.word = chain[i];
            d.index = i[2:0];
            d.last = (i == 4);
            digest_q = {digest_q, d};
        end
        clear_state();
    endtask

    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            clear_state();
            digest_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest beat %h idx %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_tdata !== exp_beat.word || m_tuser !== exp_beat.index ||
                        m_tlast !== exp_beat.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_beat.word, exp_beat.index, exp_beat.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) finish_message();
                else take_byte(s_tdata);
            end
        end
        fail_count <= mismatches;
        pending <= digest_q.size();
    end
endmodule

// File: sim/tb_top.sv
// tb_top: stimulus and verdict for the ripemd-160 engine
// depends on ripemd160_hash_engine_core and rmd160_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    always #6 aclk = ~aclk;

    ripemd160_hash_engine_core u_dut (.*);

    rmd160_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(logic mode, logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_beat(1'b0, 8'($urandom));
        send_beat(1'b1, 8'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: empty message, extremes, finish with junk byte
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'hAA);
        send_beat(1'b0, 8'h55);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b0, 8'h61);
        send_beat(1'b1, 8'h00);
        idle_input();
        wait (pending == 0);
        @(negedge aclk);
        // full block then finish at byte 55, padding that spills into a second block
        send_message(119);
        send_message(60);
        for (int m = 0; m < 4; m++) begin
            if (m == 2) calm = 1'b1;
            send_message($urandom_range(0, 6));
        end
        idle_input();
        @(negedge aclk);
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

// File: files.f
design/rmd160_pkg.sv
design/rmd160_ctrl.sv
design/rmd160_dp.sv
design/ripemd160_hash_engine_core.sv
sim/rmd160_checker.sv
sim/tb_top.sv
